FILE: rtl/bu8_pkg.sv
// ----------------------------------------------------------------------------
// bu8_pkg
// Shared types, constants and the UTF-8 encoder for the string converter.
// ----------------------------------------------------------------------------
package bu8_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] OPT_WIDE_BIT = 8'h01;
  localparam logic [7:0] OPT_PHON_BIT = 8'h04;
  localparam logic [7:0] OPT_RICH_BIT = 8'h08;

  localparam logic [15:0] LIM_ONE_BYTE = 16'h0080;
  localparam logic [15:0] LIM_TWO_BYTE = 16'h0800;

  localparam logic [2:0] LEAD_TWO   = 3'b110;
  localparam logic [3:0] LEAD_THREE = 4'b1110;
  localparam logic [1:0] CONT_MARK  = 2'b10;

  localparam logic [1:0] NB_STATUS = 2'd0;
  localparam logic [1:0] NB_ONE    = 2'd1;
  localparam logic [1:0] NB_TWO    = 2'd2;
  localparam logic [1:0] NB_THREE  = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CNT_HI,
    PH_OPT,
    PH_RICH_CNT,
    PH_PHON_SZ,
    PH_CHARS,
    PH_RICH_SKIP,
    PH_PHON_SKIP
  } phase_t;

  // One parsed input word: up to three output bytes, or a status-only entry.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       done;
  } entry_t;

  function automatic entry_t encode_utf8(input logic [15:0] ch);
    entry_t e;
    e = '0;
    if (ch < LIM_ONE_BYTE) begin
      e.b0     = ch[7:0];
      e.nbytes = NB_ONE;
    end else if (ch < LIM_TWO_BYTE) begin
      e.b0     = {LEAD_TWO, ch[10:6]};
      e.b1     = {CONT_MARK, ch[5:0]};
      e.nbytes = NB_TWO;
    end else begin
      e.b0     = {LEAD_THREE, ch[15:12]};
      e.b1     = {CONT_MARK, ch[11:6]};
      e.b2     = {CONT_MARK, ch[5:0]};
      e.nbytes = NB_THREE;
    end
    return e;
  endfunction

endpackage

FILE: rtl/bu8_front.sv
// ----------------------------------------------------------------------------
// bu8_front
// Parses string record bytes and encodes each character into a queue entry.
// ----------------------------------------------------------------------------
module bu8_front import bu8_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] data_byte,
  input  logic       begin_string,
  input  logic       count_two_bytes,
  input  logic       first_of_record,
  input  logic       accept,
  output entry_t     entry
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] chars_r, chars_nxt;
  logic        wide_r, wide_nxt;
  logic        rich_f_r, rich_f_nxt;
  logic        phon_f_r, phon_f_nxt;
  logic [17:0] rich_r, rich_nxt;
  logic [31:0] phon_r, phon_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [1:0]  hbi_r, hbi_nxt;

  logic   go_body;
  logic   go_trailers;
  logic   done;
  entry_t enc;

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    chars_nxt   = chars_r;
    wide_nxt    = wide_r;
    rich_f_nxt  = rich_f_r;
    phon_f_nxt  = phon_f_r;
    rich_nxt    = rich_r;
    phon_nxt    = phon_r;
    low_nxt     = low_r;
    hbi_nxt     = hbi_r;
    go_body     = 1'b0;
    go_trailers = 1'b0;
    done        = 1'b0;
    enc         = '0;
    if (begin_string) begin
      hbi_nxt   = '0;
      rich_nxt  = '0;
      phon_nxt  = '0;
      chars_nxt = '0;
      if (count_two_bytes) begin
        low_nxt   = data_byte;
        phase_nxt = PH_CNT_HI;
      end else begin
        count_nxt = {8'h00, data_byte};
        phase_nxt = PH_OPT;
      end
    end else begin
      unique case (phase_r)
        PH_CNT_HI: begin
          count_nxt = {data_byte, low_r};
          phase_nxt = PH_OPT;
        end
        PH_OPT: begin
          wide_nxt   = |(data_byte & OPT_WIDE_BIT);
          phon_f_nxt = |(data_byte & OPT_PHON_BIT);
          rich_f_nxt = |(data_byte & OPT_RICH_BIT);
          chars_nxt  = count_r;
          rich_nxt   = '0;
          phon_nxt   = '0;
          hbi_nxt    = '0;
          if (rich_f_nxt) begin
            phase_nxt = PH_RICH_CNT;
          end else if (phon_f_nxt) begin
            phase_nxt = PH_PHON_SZ;
          end else begin
            go_body = 1'b1;
          end
        end
        PH_RICH_CNT: begin
          if (hbi_r == 2'd0) begin
            rich_nxt = {10'd0, data_byte};
            hbi_nxt  = 2'd1;
          end else begin
            rich_nxt = {data_byte, rich_r[7:0], 2'b00};
            hbi_nxt  = 2'd0;
            if (phon_f_r) begin
              phase_nxt = PH_PHON_SZ;
            end else begin
              go_body = 1'b1;
            end
          end
        end
        PH_PHON_SZ: begin
          unique case (hbi_r)
            2'd0:    phon_nxt[7:0]   = phon_r[7:0]   | data_byte;
            2'd1:    phon_nxt[15:8]  = phon_r[15:8]  | data_byte;
            2'd2:    phon_nxt[23:16] = phon_r[23:16] | data_byte;
            default: phon_nxt[31:24] = phon_r[31:24] | data_byte;
          endcase
          if (hbi_r == 2'd3) begin
            go_body = 1'b1;
          end else begin
            hbi_nxt = hbi_r + 2'd1;
          end
        end
        PH_CHARS: begin
          if (hbi_r == 2'd0) begin
            if (first_of_record) begin
              wide_nxt = |(data_byte & OPT_WIDE_BIT);
            end else if (wide_r) begin
              low_nxt = data_byte;
              hbi_nxt = 2'd1;
            end else begin
              enc       = encode_utf8({8'h00, data_byte});
              chars_nxt = chars_r - 16'd1;
              go_trailers = (chars_nxt == '0);
            end
          end else begin
            enc         = encode_utf8({data_byte, low_r});
            hbi_nxt     = 2'd0;
            chars_nxt   = chars_r - 16'd1;
            go_trailers = (chars_nxt == '0);
          end
        end
        PH_RICH_SKIP: begin
          rich_nxt    = rich_r - 18'd1;
          go_trailers = (rich_nxt == '0);
        end
        PH_PHON_SKIP: begin
          phon_nxt    = phon_r - 32'd1;
          go_trailers = (phon_nxt == '0);
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    if (go_body) begin
      hbi_nxt = '0;
      if (chars_nxt != '0) begin
        phase_nxt = PH_CHARS;
      end else begin
        go_trailers = 1'b1;
      end
    end
    if (go_trailers) begin
      priority if (rich_nxt != '0) begin
        phase_nxt = PH_RICH_SKIP;
      end else if (phon_nxt != '0) begin
        phase_nxt = PH_PHON_SKIP;
      end else begin
        phase_nxt = PH_IDLE;
        done      = 1'b1;
      end
    end
  end

  always_comb begin
    entry      = enc;
    entry.done = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      count_r  <= '0;
      chars_r  <= '0;
      wide_r   <= 1'b0;
      rich_f_r <= 1'b0;
      phon_f_r <= 1'b0;
      rich_r   <= '0;
      phon_r   <= '0;
      low_r    <= '0;
      hbi_r    <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      chars_r  <= chars_nxt;
      wide_r   <= wide_nxt;
      rich_f_r <= rich_f_nxt;
      phon_f_r <= phon_f_nxt;
      rich_r   <= rich_nxt;
      phon_r   <= phon_nxt;
      low_r    <= low_nxt;
      hbi_r    <= hbi_nxt;
    end
  end

endmodule

FILE: rtl/bu8_fifo.sv
// ----------------------------------------------------------------------------
// bu8_fifo
// Short queue of encoded entries between the parser and the byte emitter.
// ----------------------------------------------------------------------------
module bu8_fifo import bu8_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t wdata,
  output logic   full,
  input  logic   pop,
  output entry_t rdata,
  output logic   empty
);

  entry_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr_r, rptr_r;
  logic [FIFO_AW:0]     cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + (FIFO_AW+1)'(1);
      2'b01:   cnt_nxt = cnt_r - (FIFO_AW+1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wptr_r <= wptr_r + FIFO_AW'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/bu8_back.sv
// ----------------------------------------------------------------------------
// bu8_back
// Walks the head entry and presents its bytes one result word at a time.
// ----------------------------------------------------------------------------
module bu8_back import bu8_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  entry_t     head,
  input  logic       head_empty,
  output logic       head_pop,
  input  logic       pop,
  output logic [7:0] utf8_byte,
  output logic       byte_valid,
  output logic       last_of_run,
  output logic       string_done
);

  logic [1:0] idx_r, idx_nxt;
  logic       take;

  always_comb begin
    byte_valid = (head.nbytes != NB_STATUS);
    unique case (idx_r)
      2'd0:    utf8_byte = head.b0;
      2'd1:    utf8_byte = head.b1;
      default: utf8_byte = head.b2;
    endcase
    if (!byte_valid) begin
      utf8_byte   = '0;
      last_of_run = 1'b1;
    end else begin
      last_of_run = (idx_r == head.nbytes - 2'd1);
    end
    string_done = last_of_run && head.done;
  end

  assign take     = pop && !head_empty;
  assign head_pop = take && last_of_run;

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = last_of_run ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

FILE: rtl/biff_unicode_string_to_utf8.sv
// ----------------------------------------------------------------------------
// biff_unicode_string_to_utf8
// Converts spreadsheet string record payload bytes into a UTF-8 byte stream.
//
//   channel  dir  handshake      payload
//   in_      in   push / full    data_byte, begin_string, count_two_bytes,
//                                first_of_record
//   out_     out  pop / empty    utf8_byte, byte_valid, last_of_run, string_done
//
// The parser takes one byte per cycle while the entry queue has room.
// Each input byte yields one to three result words, one per cycle while
// out_pop is high, so the sustained rate is set by the result port.
// Reset is synchronous and leaves the queue empty. Either side may stall;
// the queue decouples them.
// ----------------------------------------------------------------------------
module biff_unicode_string_to_utf8 import bu8_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_begin_string,
  input  logic       in_count_two_bytes,
  input  logic       in_first_of_record,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_utf8_byte,
  output logic       out_byte_valid,
  output logic       out_last_of_run,
  output logic       out_string_done
);

  entry_t wr_entry;
  entry_t rd_entry;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;
  logic   accept;

  assign in_full   = q_full;
  assign out_empty = q_empty;
  assign accept    = in_push && !q_full;

  bu8_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .data_byte       (in_data_byte),
    .begin_string    (in_begin_string),
    .count_two_bytes (in_count_two_bytes),
    .first_of_record (in_first_of_record),
    .accept          (accept),
    .entry           (wr_entry)
  );

  bu8_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (wr_entry),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (rd_entry),
    .empty (q_empty)
  );

  bu8_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (rd_entry),
    .head_empty  (q_empty),
    .head_pop    (q_pop),
    .pop         (out_pop),
    .utf8_byte   (out_utf8_byte),
    .byte_valid  (out_byte_valid),
    .last_of_run (out_last_of_run),
    .string_done (out_string_done)
  );

endmodule

FILE: rtl/bu8_checker.sv
// ----------------------------------------------------------------------------
// bu8_checker
// Port-level checks on the converter's result stream.
// ----------------------------------------------------------------------------
module bu8_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_push,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_utf8_byte,
  input logic       out_byte_valid,
  input logic       out_last_of_run,
  input logic       out_string_done
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_utf8_byte) && $stable(out_byte_valid) &&
       $stable(out_last_of_run) && $stable(out_string_done)))
    else $error("stalled result word changed");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_byte_valid) |-> (out_utf8_byte == 8'h00 && out_last_of_run))
    else $error("status word carries data or is not last");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_string_done) |-> out_last_of_run)
    else $error("string end flagged before last word");

  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last_of_run) |=> !out_empty)
    else $error("run cut short");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && out_empty) |=> !out_empty)
    else $error("accepted byte produced no result");

endmodule

bind biff_unicode_string_to_utf8 bu8_checker u_bu8_checker (.*);
